>>> sv/cobsrx_pkg.sv
// ----------------------------------------------------------------------------
// COBS frame receiver package
// Shared constants, codes and the CRC-16/CCITT byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cobsrx_pkg;

   localparam int unsigned RAW_FRAME_MAX   = 1024;
   localparam int unsigned RAW_COUNT_WIDTH = $clog2(RAW_FRAME_MAX);
   localparam int unsigned LEN_WIDTH       = 10;
   localparam int unsigned CSR_IDX_WIDTH   = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 10;

   localparam logic [LEN_WIDTH-1:0] LEN_MAX     = '1;
   localparam logic [LEN_WIDTH-1:0] MIN_LENGTH  = LEN_WIDTH'(3);
   localparam logic [15:0]          CRC_INIT    = 16'hFFFF;
   localparam logic [15:0]          CRC_POLY    = 16'h1021;
   localparam logic [7:0]           FULL_GROUP  = 8'hFF;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STATUS_TYPE_ID = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SENSOR_TYPE_ID = CSR_IDX_WIDTH'(1);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STATUS_LENGTH  = CSR_IDX_WIDTH'(2);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SENSOR_LENGTH  = CSR_IDX_WIDTH'(3);

   typedef enum logic [2:0] {
      VERDICT_SHORT       = 3'd0,
      VERDICT_BAD_CRC     = 3'd1,
      VERDICT_STATUS_OK   = 3'd2,
      VERDICT_STATUS_SIZE = 3'd3,
      VERDICT_SENSOR_OK   = 3'd4,
      VERDICT_SENSOR_SIZE = 3'd5,
      VERDICT_UNKNOWN     = 3'd6,
      VERDICT_OVERFLOW    = 3'd7
   } verdict_type;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_VERDICT = 1'b1
   } item_kind_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> sv/cobs_crc_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// COBS frame receiver with CRC-16/CCITT check
// Decodes stuffed bytes, streams them out and closes each frame with a verdict.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears in the cycle after its raw byte is accepted.
// Throughput: one raw byte per cycle; the single decode and checksum stage
// sets this, and the result register stalls the input only while it is full.
// Reset: synchronous and active high; clears frame state, the result valid flag
// and configuration to their default values.
`default_nettype none

module cobs_crc_frame_receiver_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [7:0]                             req_rx_byte,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_item_kind,
   output logic [7:0]                                  rsp_data_byte,
   output logic [2:0]                                  rsp_verdict,
   output logic [cobsrx_pkg::LEN_WIDTH-1:0]            rsp_decoded_length,
   output logic                                        rsp_frame_last,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cobsrx_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [cobsrx_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   import cobsrx_pkg::*;

   logic [7:0]                 status_type_id_ff;
   logic [7:0]                 sensor_type_id_ff;
   logic [LEN_WIDTH-1:0]       status_length_ff;
   logic [LEN_WIDTH-1:0]       sensor_length_ff;

   logic [7:0]                 group_remaining_ff, group_remaining_in;
   logic                       group_was_full_ff, group_was_full_in;
   logic [RAW_COUNT_WIDTH-1:0] raw_count_ff, raw_count_in;
   logic [LEN_WIDTH-1:0]       decoded_count_ff, decoded_count_in;
   logic [15:0]                checksum_acc_ff, checksum_acc_in;
   logic [7:0]                 tail0_ff, tail0_in;
   logic [7:0]                 tail1_ff, tail1_in;
   logic [7:0]                 frame_type_ff, frame_type_in;

   logic                       rsp_valid_ff;
   item_kind_type              rsp_kind_ff, rsp_kind_in;
   logic [7:0]                 rsp_data_ff, rsp_data_in;
   verdict_type                rsp_verdict_ff, rsp_verdict_in;
   logic [LEN_WIDTH-1:0]       rsp_length_ff, rsp_length_in;
   logic                       result_in;

   logic                       accept;
   logic                       take;
   logic [7:0]                 take_byte;
   logic                       clear;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_type_id_ff <= 8'd0;
         sensor_type_id_ff <= 8'd1;
         status_length_ff  <= MIN_LENGTH;
         sensor_length_ff  <= MIN_LENGTH;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STATUS_TYPE_ID: status_type_id_ff <= csr_wdata[7:0];
            CSR_SENSOR_TYPE_ID: sensor_type_id_ff <= csr_wdata[7:0];
            CSR_STATUS_LENGTH:  status_length_ff  <= csr_wdata[LEN_WIDTH-1:0];
            CSR_SENSOR_LENGTH:  sensor_length_ff  <= csr_wdata[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      group_remaining_in = group_remaining_ff;
      group_was_full_in  = group_was_full_ff;
      raw_count_in       = raw_count_ff;
      decoded_count_in   = decoded_count_ff;
      checksum_acc_in    = checksum_acc_ff;
      tail0_in           = tail0_ff;
      tail1_in           = tail1_ff;
      frame_type_in      = frame_type_ff;
      result_in          = 1'b0;
      rsp_kind_in        = KIND_DATA;
      rsp_data_in        = 8'd0;
      rsp_verdict_in     = VERDICT_SHORT;
      rsp_length_in      = '0;
      take               = 1'b0;
      take_byte          = 8'd0;
      clear              = 1'b0;

      priority if (raw_count_ff >= RAW_COUNT_WIDTH'(RAW_FRAME_MAX - 1)) begin
         result_in      = 1'b1;
         rsp_kind_in    = KIND_VERDICT;
         rsp_verdict_in = VERDICT_OVERFLOW;
         rsp_length_in  = decoded_count_ff;
         clear          = 1'b1;
      end else if (req_rx_byte == 8'd0) begin
         result_in     = 1'b1;
         rsp_kind_in   = KIND_VERDICT;
         rsp_length_in = decoded_count_ff;
         clear         = 1'b1;
         priority if (decoded_count_ff < MIN_LENGTH) begin
            rsp_verdict_in = VERDICT_SHORT;
         end else if (checksum_acc_ff != {tail1_ff, tail0_ff}) begin
            rsp_verdict_in = VERDICT_BAD_CRC;
         end else if (frame_type_ff == status_type_id_ff) begin
            rsp_verdict_in = (decoded_count_ff == status_length_ff) ?
                             VERDICT_STATUS_OK : VERDICT_STATUS_SIZE;
         end else if (frame_type_ff == sensor_type_id_ff) begin
            rsp_verdict_in = (decoded_count_ff == sensor_length_ff) ?
                             VERDICT_SENSOR_OK : VERDICT_SENSOR_SIZE;
         end else begin
            rsp_verdict_in = VERDICT_UNKNOWN;
         end
      end else begin
         raw_count_in = raw_count_ff + RAW_COUNT_WIDTH'(1);
         if (group_remaining_ff == 8'd0) begin
            group_remaining_in = req_rx_byte - 8'd1;
            group_was_full_in  = (req_rx_byte == FULL_GROUP);
            if (!group_was_full_ff) begin
               take      = 1'b1;
               take_byte = 8'd0;
               result_in = 1'b1;
            end
         end else begin
            group_remaining_in = group_remaining_ff - 8'd1;
            take               = 1'b1;
            take_byte          = req_rx_byte;
            result_in          = 1'b1;
            rsp_data_in        = req_rx_byte;
         end
      end

      if (take) begin
         if (decoded_count_ff == '0) begin
            frame_type_in = take_byte;
         end
         if (decoded_count_ff >= LEN_WIDTH'(2)) begin
            checksum_acc_in = crc_feed(checksum_acc_ff, tail0_ff);
         end
         tail0_in = tail1_ff;
         tail1_in = take_byte;
         if (decoded_count_ff != LEN_MAX) begin
            decoded_count_in = decoded_count_ff + LEN_WIDTH'(1);
         end
      end

      if (clear) begin
         group_remaining_in = 8'd0;
         group_was_full_in  = 1'b1;
         raw_count_in       = '0;
         decoded_count_in   = '0;
         checksum_acc_in    = CRC_INIT;
         tail0_in           = 8'd0;
         tail1_in           = 8'd0;
         frame_type_in      = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_remaining_ff <= 8'd0;
         group_was_full_ff  <= 1'b1;
         raw_count_ff       <= '0;
         decoded_count_ff   <= '0;
         checksum_acc_ff    <= CRC_INIT;
         tail0_ff           <= 8'd0;
         tail1_ff           <= 8'd0;
         frame_type_ff      <= 8'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept) begin
            group_remaining_ff <= group_remaining_in;
            group_was_full_ff  <= group_was_full_in;
            raw_count_ff       <= raw_count_in;
            decoded_count_ff   <= decoded_count_in;
            checksum_acc_ff    <= checksum_acc_in;
            tail0_ff           <= tail0_in;
            tail1_ff           <= tail1_in;
            frame_type_ff      <= frame_type_in;
         end
         if (accept && result_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result_in) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_length_ff  <= rsp_length_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item_kind      = rsp_kind_ff;
   assign rsp_data_byte      = rsp_data_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_decoded_length = rsp_length_ff;
   assign rsp_frame_last     = (rsp_kind_ff == KIND_VERDICT);

endmodule

`default_nettype wire
